// ===== rtl/core/slpd_pkg.sv =====
// ----------------------------------------------------------------------------
// slpd_pkg
// shared types, codes and reset values for the status led pattern driver
// ----------------------------------------------------------------------------
package slpd_pkg;

	localparam int unsigned TickW   = 32;
	localparam int unsigned PeriodW = 16;
	localparam int unsigned PatW    = 3;
	localparam int unsigned ModeW   = 2;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgW    = 16;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_SLOW_PERIOD       = 3'd0,
		CFG_MEDIUM_PERIOD     = 3'd1,
		CFG_FAST_PERIOD       = 3'd2,
		CFG_PULSE_LENGTH      = 3'd3,
		CFG_STATUS_ACTIVE_LOW = 3'd4,
		CFG_DATA_ACTIVE_LOW   = 3'd5
	} cfg_idx_t;

	localparam logic [PeriodW-1:0] SLOW_PERIOD_RST  = 16'd100;
	localparam logic [PeriodW-1:0] MEDIUM_PERIOD_RST = 16'd50;
	localparam logic [PeriodW-1:0] FAST_PERIOD_RST  = 16'd20;
	localparam logic [PeriodW-1:0] PULSE_LENGTH_RST = 16'd10;
	localparam logic               STATUS_ACTIVE_LOW_RST = 1'b1;
	localparam logic               DATA_ACTIVE_LOW_RST   = 1'b0;

	// status pattern codes
	localparam logic [ModeW-1:0] MODE_ON     = 2'd0;
	localparam logic [ModeW-1:0] MODE_SLOW   = 2'd1;
	localparam logic [ModeW-1:0] MODE_MEDIUM = 2'd2;
	localparam logic [ModeW-1:0] MODE_FAST   = 2'd3;

	// second led pattern codes
	localparam logic [PatW-1:0] PAT_OFF    = 3'd0;
	localparam logic [PatW-1:0] PAT_ON     = 3'd1;
	localparam logic [PatW-1:0] PAT_DOUBLE = 3'd5;

	typedef struct packed {
		logic              update_busy;
		logic              network_up;
		logic              broker_up;
		logic [TickW-1:0]  now_ticks;
		logic              request_valid;
		logic [PatW-1:0]   request_pattern;
	} pass_in_t;

	typedef struct packed {
		logic              status_pin;
		logic              data_pin;
		logic [ModeW-1:0]  status_mode;
		logic              double_blink_busy;
	} pass_out_t;

	typedef struct packed {
		logic [PeriodW-1:0] slow_period;
		logic [PeriodW-1:0] medium_period;
		logic [PeriodW-1:0] fast_period;
		logic [PeriodW-1:0] pulse_length;
		logic               status_active_low;
		logic               data_active_low;
	} cfg_t;

	typedef struct packed {
		logic [ModeW-1:0] mode;
		logic             driven_on;
	} status_res_t;

	typedef struct packed {
		logic driven_on;
		logic double_busy;
	} data_res_t;

	// wrapping elapsed-time test
	function automatic logic reached(input logic [TickW-1:0] now, input logic [TickW-1:0] mark,
		input logic [PeriodW-1:0] period);
		logic [TickW-1:0] elapsed;
		elapsed = now - mark;
		return elapsed >= {{(TickW-PeriodW){1'b0}}, period};
	endfunction

endpackage

// ===== rtl/core/slpd_stream_if.sv =====
// ----------------------------------------------------------------------------
// slpd_stream_if
// valid/ready channel carrying one payload struct
// ----------------------------------------------------------------------------
interface slpd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/slpd_status.sv =====
// ----------------------------------------------------------------------------
// slpd_status
// status led mode selection, blink timing and held state
// ----------------------------------------------------------------------------
module slpd_status
	import slpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  pass_in_t          pass,
	input  cfg_t              cfg,
	output status_res_t       res
);

	logic [TickW-1:0]   status_mark_q;
	logic               status_lit_q;
	logic               status_driven_on_q;
	logic [ModeW-1:0]   mode;
	logic               driven_on;
	logic [PeriodW-1:0] period;
	logic               hit;

	always_comb begin
		priority if (pass.update_busy) begin
			mode = MODE_FAST;
		end else if (pass.network_up) begin
			mode = pass.broker_up ? MODE_ON : MODE_MEDIUM;
		end else begin
			mode = MODE_SLOW;
		end
	end

	always_comb begin
		unique case (mode)
			MODE_SLOW:   period = cfg.slow_period;
			MODE_MEDIUM: period = cfg.medium_period;
			default:     period = cfg.fast_period;
		endcase
	end

	// steady on never toggles
	assign hit = (mode != MODE_ON) && reached(pass.now_ticks, status_mark_q, period);

	always_comb begin
		if (mode == MODE_ON) begin
			driven_on = 1'b1;
		end else if (hit) begin
			driven_on = ~status_lit_q;
		end else begin
			driven_on = status_driven_on_q;
		end
	end

	assign res.mode      = mode;
	assign res.driven_on = driven_on;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_mark_q      <= '0;
			status_lit_q       <= 1'b0;
			status_driven_on_q <= 1'b0;
		end else if (step_en) begin
			status_driven_on_q <= driven_on;
			if (hit) begin
				status_lit_q  <= ~status_lit_q;
				status_mark_q <= pass.now_ticks;
			end
		end
	end

endmodule

// ===== rtl/core/slpd_data.sv =====
// ----------------------------------------------------------------------------
// slpd_data
// second led pattern store and double blink sequencer
// ----------------------------------------------------------------------------
module slpd_data
	import slpd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step_en,
	input  pass_in_t  pass,
	input  cfg_t      cfg,
	output data_res_t res
);

	typedef enum logic [3:0] {
		PH_FIRST_ON  = 4'b0001,
		PH_FIRST_OFF = 4'b0010,
		PH_SECOND_ON = 4'b0100,
		PH_LAST_OFF  = 4'b1000
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [PatW-1:0]  pattern_q, pattern_cur, pattern_d;
	logic [TickW-1:0] data_mark_q, mark_d;
	logic             driven_on_q, driven_on_d;
	logic             hit;

	// a request replaces the stored pattern before the pass
	assign pattern_cur = pass.request_valid ? pass.request_pattern : pattern_q;
	assign hit         = reached(pass.now_ticks, data_mark_q, cfg.pulse_length);

	always_comb begin
		phase_d     = phase_q;
		pattern_d   = pattern_cur;
		mark_d      = data_mark_q;
		driven_on_d = driven_on_q;
		if (pattern_cur == PAT_DOUBLE) begin
			unique case (phase_q)
				PH_FIRST_ON: begin
					driven_on_d = 1'b1;
					mark_d      = pass.now_ticks;
					phase_d     = PH_FIRST_OFF;
				end
				PH_FIRST_OFF: begin
					if (hit) begin
						driven_on_d = 1'b0;
						mark_d      = pass.now_ticks;
						phase_d     = PH_SECOND_ON;
					end
				end
				PH_SECOND_ON: begin
					if (hit) begin
						driven_on_d = 1'b1;
						mark_d      = pass.now_ticks;
						phase_d     = PH_LAST_OFF;
					end
				end
				default: begin
					if (hit) begin
						driven_on_d = 1'b0;
						pattern_d   = PAT_OFF;
						phase_d     = PH_FIRST_ON;
					end
				end
			endcase
		end else begin
			driven_on_d = (pattern_cur == PAT_ON);
		end
	end

	assign res.driven_on   = driven_on_d;
	assign res.double_busy = (pattern_d == PAT_DOUBLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIRST_ON;
			pattern_q   <= PAT_OFF;
			data_mark_q <= '0;
			driven_on_q <= 1'b0;
		end else if (step_en) begin
			phase_q     <= phase_d;
			pattern_q   <= pattern_d;
			data_mark_q <= mark_d;
			driven_on_q <= driven_on_d;
		end
	end

endmodule

// ===== rtl/core/slpd_cfg.sv =====
// ----------------------------------------------------------------------------
// slpd_cfg
// configuration register file with plain write port
// ----------------------------------------------------------------------------
module slpd_cfg
	import slpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_wdata,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slow_period       <= SLOW_PERIOD_RST;
			cfg_q.medium_period     <= MEDIUM_PERIOD_RST;
			cfg_q.fast_period       <= FAST_PERIOD_RST;
			cfg_q.pulse_length      <= PULSE_LENGTH_RST;
			cfg_q.status_active_low <= STATUS_ACTIVE_LOW_RST;
			cfg_q.data_active_low   <= DATA_ACTIVE_LOW_RST;
		end else if (cfg_we) begin
			// writes beyond the register list are dropped
			case (cfg_index)
				CFG_SLOW_PERIOD:       cfg_q.slow_period       <= cfg_wdata;
				CFG_MEDIUM_PERIOD:     cfg_q.medium_period     <= cfg_wdata;
				CFG_FAST_PERIOD:       cfg_q.fast_period       <= cfg_wdata;
				CFG_PULSE_LENGTH:      cfg_q.pulse_length      <= cfg_wdata;
				CFG_STATUS_ACTIVE_LOW: cfg_q.status_active_low <= cfg_wdata[0];
				CFG_DATA_ACTIVE_LOW:   cfg_q.data_active_low   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/status_led_pattern_driver.sv =====
// ----------------------------------------------------------------------------
// status_led_pattern_driver
// one service pass per transaction: status led blink by priority rule,
// second led steady or double blink, pin levels through polarity registers
// ----------------------------------------------------------------------------
//
// channel  | role | payload
// ---------+------+---------------------------------------------------------
// in_ch    | sink | update_busy, network_up, broker_up, now_ticks,
//          |      | request_valid, request_pattern
// out_ch   | src  | status_pin, data_pin, status_mode, double_blink_busy
// cfg_*    | wr   | cfg_we, cfg_index, cfg_wdata (16 bit, no read-back)
//
// one transaction per cycle sustained while out_ch is ready; a pass is
// captured in the input register, evaluated combinationally and lands in
// the output register, which offers the result on out_ch
// arst_n clears the led state, the pipeline valids and loads register defaults
// a stalled output holds its result; the input register accepts while it is
// empty or while the output register is empty or being drained in the same cycle
// ----------------------------------------------------------------------------
module status_led_pattern_driver
	import slpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	slpd_stream_if.sink        in_ch,
	slpd_stream_if.source      out_ch,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_wdata
);

	cfg_t        cfg;
	pass_in_t    pass_s1;
	logic        valid_s1;
	pass_out_t   result_q;
	logic        out_valid_q;
	logic        out_free;
	logic        advance;
	logic        in_accept;
	status_res_t status_res;
	data_res_t   data_res;

	slpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// output register can take a result this cycle
	assign out_free    = !out_valid_q || out_ch.ready;
	// the pass in the input register is evaluated and retires its state update
	assign advance     = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || out_free;
	assign in_accept   = in_ch.valid && in_ch.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pass_s1 <= in_ch.payload;
		end
	end

	// led state machines update only when the pass retires
	slpd_status u_status (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.pass    (pass_s1),
		.cfg     (cfg),
		.res     (status_res)
	);

	slpd_data u_data (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.pass    (pass_s1),
		.cfg     (cfg),
		.res     (data_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= advance || (out_valid_q && !out_ch.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			// polarity applied at the pin
			result_q.status_pin        <= status_res.driven_on ^ cfg.status_active_low;
			result_q.data_pin          <= data_res.driven_on ^ cfg.data_active_low;
			result_q.status_mode       <= status_res.mode;
			result_q.double_blink_busy <= data_res.double_busy;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = result_q;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the status led pattern driver: service passes are
// queued and driven on the input channel, each accepted pass is run through a
// local predictor of both leds, and every result on the output channel is
// compared field by field with the oldest predicted result
// ----------------------------------------------------------------------------
module tb_top;
	import slpd_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgW-1:0] cfg_wdata;

	slpd_stream_if #(.payload_t(pass_in_t)) pass_ch();
	slpd_stream_if #(.payload_t(pass_out_t)) leds_ch();

	status_led_pattern_driver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (pass_ch),
		.out_ch    (leds_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// predictor: shadow registers, set by reset and register writes, and led state, updated once per accepted pass
	// ------------------------------------------------------------------------
	cfg_t led_cfg;

	logic [TickW-1:0] status_mark;
	logic             status_lit;        // blink toggle state
	logic             status_on;         // status led currently lit
	logic [TickW-1:0] data_mark;
	logic [1:0]       dbl_phase;
	logic [PatW-1:0]  data_pattern;
	logic             data_on;           // second led currently lit

	task automatic reset_predictor();
		led_cfg.slow_period       = SLOW_PERIOD_RST;
		led_cfg.medium_period     = MEDIUM_PERIOD_RST;
		led_cfg.fast_period       = FAST_PERIOD_RST;
		led_cfg.pulse_length      = PULSE_LENGTH_RST;
		led_cfg.status_active_low = STATUS_ACTIVE_LOW_RST;
		led_cfg.data_active_low   = DATA_ACTIVE_LOW_RST;
		status_mark  = '0;
		status_lit   = 1'b0;
		status_on    = 1'b0;
		data_mark    = '0;
		dbl_phase    = '0;
		data_pattern = PAT_OFF;
		data_on      = 1'b0;
	endtask

	// elapsed ticks since mark, modulo 2^32, against a 16 bit period
	function automatic logic period_elapsed(input logic [TickW-1:0] now,
		input logic [TickW-1:0] mark, input logic [PeriodW-1:0] period);
		logic [TickW-1:0] since;
		since = now - mark;
		return since >= TickW'(period);
	endfunction

	function automatic pass_out_t led_pass(input pass_in_t p);
		pass_out_t r;
		logic [ModeW-1:0] mode;
		logic [PeriodW-1:0] period;

		if (p.request_valid)
			data_pattern = p.request_pattern;

		// priority: update in progress, then network plus broker, then network
		if (p.update_busy)
			mode = MODE_FAST;
		else if (p.network_up)
			mode = p.broker_up ? MODE_ON : MODE_MEDIUM;
		else
			mode = MODE_SLOW;

		if (mode == MODE_ON) begin
			// steady on leaves the toggle state alone
			status_on = 1'b1;
		end else begin
			case (mode)
				MODE_SLOW:   period = led_cfg.slow_period;
				MODE_MEDIUM: period = led_cfg.medium_period;
				default:     period = led_cfg.fast_period;
			endcase
			if (period_elapsed(p.now_ticks, status_mark, period)) begin
				status_lit  = !status_lit;
				status_on   = status_lit;
				status_mark = p.now_ticks;
			end
		end

		if (data_pattern == PAT_DOUBLE) begin
			// on, off, on, off, then back to the off pattern
			case (dbl_phase)
				2'd0: begin
					data_on   = 1'b1;
					data_mark = p.now_ticks;
					dbl_phase = 2'd1;
				end
				2'd1: begin
					if (period_elapsed(p.now_ticks, data_mark, led_cfg.pulse_length)) begin
						data_on   = 1'b0;
						data_mark = p.now_ticks;
						dbl_phase = 2'd2;
					end
				end
				2'd2: begin
					if (period_elapsed(p.now_ticks, data_mark, led_cfg.pulse_length)) begin
						data_on   = 1'b1;
						data_mark = p.now_ticks;
						dbl_phase = 2'd3;
					end
				end
				default: begin
					if (period_elapsed(p.now_ticks, data_mark, led_cfg.pulse_length)) begin
						data_on      = 1'b0;
						data_pattern = PAT_OFF;
						dbl_phase    = 2'd0;
					end
				end
			endcase
		end else begin
			// blink codes and unused codes leave the second led dark
			data_on = (data_pattern == PAT_ON);
		end

		r.status_pin        = status_on ^ led_cfg.status_active_low;
		r.data_pin          = data_on ^ led_cfg.data_active_low;
		r.status_mode       = mode;
		r.double_blink_busy = (data_pattern == PAT_DOUBLE);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// queues and flow control shared by the stimulus, driver and monitor
	// ------------------------------------------------------------------------
	pass_in_t  passes_q[$];         // service passes not yet accepted
	pass_out_t leds_expected_q[$];  // predicted results not yet seen
	int        mismatches = 0;
	logic      pass_taken = 1'b0;   // set at the edge where a transaction went in
	logic      no_idle = 1'b0;      // no idle gaps in the tail of the run
	int        send_gap = 0;
	int        recv_gap = 0;
	int        hold_left = 0;       // long receiver hold-off, in cycles

	// driver: offer the oldest pending pass, keep it until the transaction
	always @(negedge clk) begin
		if (!pass_ch.valid || pass_taken) begin
			pass_taken = 1'b0;
			if (send_gap > 0 && !no_idle) begin
				pass_ch.valid <= 1'b0;
				send_gap--;
			end else if (passes_q.size() > 0) begin
				if (!no_idle && $urandom_range(0, 11) == 0) begin
					send_gap = int'($urandom_range(1, 8)) - 1;
					pass_ch.valid <= 1'b0;
				end else begin
					pass_ch.valid   <= 1'b1;
					pass_ch.payload <= passes_q[0];
				end
			end else begin
				pass_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: random stall bursts, plus the long hold-off when requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			leds_ch.ready <= 1'b0;
			hold_left--;
		end else if (no_idle) begin
			leds_ch.ready <= 1'b1;
		end else if (recv_gap > 0) begin
			leds_ch.ready <= 1'b0;
			recv_gap--;
		end else if ($urandom_range(0, 9) == 0) begin
			recv_gap = int'($urandom_range(1, 8)) - 1;
			leds_ch.ready <= 1'b0;
		end else begin
			leds_ch.ready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin
		pass_out_t want;
		pass_out_t got;
		if (arst_n && pass_ch.valid && pass_ch.ready) begin
			void'(passes_q.pop_front());
			leds_expected_q.push_back(led_pass(pass_ch.payload));
			pass_taken = 1'b1;
		end
		if (arst_n && leds_ch.valid && leds_ch.ready) begin
			got = leds_ch.payload;
			if (leds_expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %b", $time, got);
				mismatches++;
			end else begin
				want = leds_expected_q.pop_front();
				check_field("status_pin", want.status_pin, got.status_pin);
				check_field("data_pin", want.data_pin, got.data_pin);
				check_field("status_mode", want.status_mode, got.status_mode);
				check_field("double_blink_busy", want.double_blink_busy,
					got.double_blink_busy);
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	logic [TickW-1:0] tick_cursor = '0;
	logic cur_busy = 1'b0;
	logic cur_net = 1'b0;
	logic cur_broker = 1'b0;

	// register writes happen only with the block idle
	task automatic write_reg(input cfg_idx_t idx, input logic [CfgW-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SLOW_PERIOD:       led_cfg.slow_period = value;
			CFG_MEDIUM_PERIOD:     led_cfg.medium_period = value;
			CFG_FAST_PERIOD:       led_cfg.fast_period = value;
			CFG_PULSE_LENGTH:      led_cfg.pulse_length = value;
			CFG_STATUS_ACTIVE_LOW: led_cfg.status_active_low = value[0];
			CFG_DATA_ACTIVE_LOW:   led_cfg.data_active_low = value[0];
			default: ;
		endcase
	endtask

	task automatic set_periods(input logic [CfgW-1:0] slow, input logic [CfgW-1:0] med,
		input logic [CfgW-1:0] fast, input logic [CfgW-1:0] pulse,
		input logic status_low, input logic data_low);
		write_reg(CFG_SLOW_PERIOD, slow);
		write_reg(CFG_MEDIUM_PERIOD, med);
		write_reg(CFG_FAST_PERIOD, fast);
		write_reg(CFG_PULSE_LENGTH, pulse);
		write_reg(CFG_STATUS_ACTIVE_LOW, {15'd0, status_low});
		write_reg(CFG_DATA_ACTIVE_LOW, {15'd0, data_low});
	endtask

	task automatic queue_pass(input logic busy, input logic net, input logic broker,
		input logic [TickW-1:0] now, input logic req, input logic [PatW-1:0] pattern);
		pass_in_t p;
		p.update_busy     = busy;
		p.network_up      = net;
		p.broker_up       = broker;
		p.now_ticks       = now;
		p.request_valid   = req;
		p.request_pattern = pattern;
		passes_q.push_back(p);
	endtask

	// time mostly moves forward in small steps so blinks and double blinks
	// run their course; now and then the timestamp jumps anywhere
	task automatic queue_passes(input int count, input int unsigned step_max);
		logic req;
		logic [PatW-1:0] pattern;
		repeat (count) begin
			if ($urandom_range(0, 7) == 0)
				{cur_busy, cur_net, cur_broker} = 3'($urandom_range(0, 7));
			if ($urandom_range(0, 24) == 0)
				tick_cursor = $urandom();
			else
				tick_cursor = tick_cursor + $urandom_range(0, step_max);
			req = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 2) == 0)
				pattern = PAT_DOUBLE;
			else
				pattern = PatW'($urandom_range(0, 7));
			queue_pass(cur_busy, cur_net, cur_broker, tick_cursor, req, pattern);
		end
	endtask

	task automatic wait_drained();
		while (passes_q.size() != 0 || leds_expected_q.size() != 0)
			@(posedge clk);
		// two-stage pipeline, let it settle
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// run sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		pass_ch.valid   = 1'b0;
		pass_ch.payload = '0;
		leds_ch.ready   = 1'b0;
		reset_predictor();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed passes on register defaults: every priority combination,
		// every second led code, double blink with a request in the middle,
		// timestamp extremes and wrap
		queue_pass(1'b0, 1'b0, 1'b0, 32'd0,   1'b0, PAT_OFF);
		queue_pass(1'b0, 1'b0, 1'b0, 32'd100, 1'b1, PAT_ON);
		queue_pass(1'b1, 1'b1, 1'b1, 32'd110, 1'b1, PAT_OFF);
		queue_pass(1'b1, 1'b0, 1'b0, 32'd130, 1'b0, 3'd7);
		queue_pass(1'b0, 1'b1, 1'b1, 32'd131, 1'b1, 3'd2);
		queue_pass(1'b0, 1'b1, 1'b0, 32'd180, 1'b1, 3'd3);
		queue_pass(1'b0, 1'b0, 1'b1, 32'd181, 1'b1, 3'd4);
		queue_pass(1'b1, 1'b1, 1'b0, 32'd200, 1'b1, 3'd6);
		queue_pass(1'b1, 1'b0, 1'b1, 32'd201, 1'b1, 3'd7);
		queue_pass(1'b0, 1'b1, 1'b1, 32'd202, 1'b1, PAT_DOUBLE);
		queue_pass(1'b0, 1'b1, 1'b1, 32'd207, 1'b0, PAT_OFF);
		queue_pass(1'b0, 1'b1, 1'b1, 32'd212, 1'b0, PAT_OFF);
		queue_pass(1'b0, 1'b1, 1'b1, 32'd213, 1'b1, PAT_ON);
		queue_pass(1'b0, 1'b1, 1'b1, 32'd230, 1'b1, PAT_DOUBLE);
		queue_pass(1'b0, 1'b1, 1'b1, 32'd239, 1'b0, PAT_OFF);
		queue_pass(1'b0, 1'b1, 1'b1, 32'd240, 1'b0, PAT_OFF);
		queue_pass(1'b0, 1'b0, 1'b0, 32'hFFFF_FFF0, 1'b1, PAT_DOUBLE);
		queue_pass(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, PAT_OFF);
		queue_pass(1'b0, 1'b0, 1'b0, 32'h0000_0005, 1'b0, PAT_OFF);
		queue_pass(1'b1, 1'b0, 1'b0, 32'h0000_0010, 1'b0, PAT_OFF);
		queue_pass(1'b0, 1'b0, 1'b0, 32'h0000_0010, 1'b0, PAT_OFF);
		queue_pass(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, PAT_OFF);
		queue_pass(1'b0, 1'b0, 1'b0, 32'hAAAA_5555, 1'b1, PAT_OFF);
		queue_pass(1'b0, 1'b0, 1'b0, 32'h5555_AAAA, 1'b0, PAT_OFF);
		wait_drained();

		// short periods, polarities flipped; the receiver holds off long
		// enough for the pipeline to fill and push back on the sender
		set_periods(16'd7, 16'd4, 16'd2, 16'd3, 1'b0, 1'b1);
		queue_passes(120, 10);
		repeat (20) @(posedge clk);
		hold_left = 80;
		wait_drained();

		// zero periods: every blinking status pass toggles and every double blink pass advances
		set_periods(16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1);
		queue_passes(60, 3);
		wait_drained();

		// largest periods with large time steps
		set_periods(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
		queue_passes(60, 40000);
		wait_drained();

		// random small settings
		set_periods(CfgW'($urandom_range(1, 16)), CfgW'($urandom_range(1, 16)),
			CfgW'($urandom_range(1, 16)), CfgW'($urandom_range(1, 16)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		queue_passes(120, 12);
		wait_drained();

		// mixed extremes, both sides running without gaps
		set_periods(16'd1, 16'hFFFF, 16'd5, 16'd1, 1'b1, 1'b0);
		no_idle = 1'b1;
		queue_passes(90, 6);
		wait_drained();

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#3000000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
